>>> design/sar_pkg.sv
// shared types and codes for the scroll and address register unit
// no dependencies
`default_nettype none

package sar_pkg;

  localparam int unsigned ADDR_W = 15;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned FINE_W = 3;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned PORT_W = 3;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [FINE_W-1:0] fine_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REG_WRITE = 3'd0,
    KIND_REG_READ  = 3'd1,
    KIND_INC_X     = 3'd2,
    KIND_INC_Y     = 3'd3,
    KIND_COPY_H    = 3'd4,
    KIND_COPY_V    = 3'd5
  } kind_t;

  typedef enum logic [PORT_W-1:0] {
    PORT_CONTROL = 3'd0,
    PORT_STATUS  = 3'd2,
    PORT_SCROLL  = 3'd5,
    PORT_ADDRESS = 3'd6,
    PORT_DATA    = 3'd7
  } port_t;

  localparam logic [4:0] COARSE_MAX      = 5'd31;
  localparam logic [4:0] COARSE_Y_LAST   = 5'd29;
  localparam logic [2:0] FINE_Y_MAX      = 3'd7;
  localparam addr_t      ROW_STEP        = addr_t'(32);
  localparam addr_t      COL_STEP        = addr_t'(1);

  // coarse x step, wraps into the next horizontal nametable
  function automatic addr_t inc_x(input addr_t v);
    addr_t r;
    r = v;
    if (v[4:0] == COARSE_MAX) begin
      r[4:0] = '0;
      r[10]  = ~v[10];
    end else begin
      r[4:0] = v[4:0] + 5'd1;
    end
    return r;
  endfunction

  // fine y step, carries into coarse y
  function automatic addr_t inc_y(input addr_t v);
    addr_t r;
    r = v;
    if (v[14:12] != FINE_Y_MAX) begin
      r[14:12] = v[14:12] + 3'd1;
    end else begin
      r[14:12] = '0;
      if (v[9:5] == COARSE_Y_LAST) begin
        r[9:5] = '0;
        r[11]  = ~v[11];
      end else if (v[9:5] == COARSE_MAX) begin
        r[9:5] = '0;
      end else begin
        r[9:5] = v[9:5] + 5'd1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/scroll_address_register_unit.sv
// scroll and address register unit: state update plus registered result stage
// depends on sar_pkg
`default_nettype none

// One request is taken per clock cycle unless a held result stalls the input.
// Each accepted request updates the current address, temporary address, fine x
// scroll, write toggle and step flag in the same cycle and produces one result
// in an output register in the next cycle; the result register decouples the
// two sides, so a new request is taken whenever the result register is empty
// or being drained.
module scroll_address_register_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           in_kind,
  input  wire logic [2:0]           in_reg_index,
  input  wire logic [7:0]           in_write_data,
  input  wire logic                 in_rendering_active,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_access_valid,
  output logic                      out_access_is_write,
  output sar_pkg::addr_t            out_access_address,
  output sar_pkg::byte_t            out_access_data,
  output sar_pkg::addr_t            out_current_address,
  output sar_pkg::fine_t            out_fine_scroll_x
);
  import sar_pkg::*;

  addr_t v_r, v_nxt;
  addr_t t_r, t_nxt;
  fine_t fine_x_r, fine_x_nxt;
  logic  first_r, first_nxt;
  logic  row_step_r, row_step_nxt;

  logic  out_valid_r;
  logic  acc_valid_r, acc_valid_nxt;
  logic  acc_wr_r, acc_wr_nxt;
  addr_t acc_addr_r, acc_addr_nxt;
  byte_t acc_data_r, acc_data_nxt;

  logic  accept;
  addr_t v_stepped;

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  // address after a data-port access
  assign v_stepped = in_rendering_active ? inc_y(v_r)
                   : v_r + (row_step_r ? ROW_STEP : COL_STEP);

  always_comb begin
    v_nxt         = v_r;
    t_nxt         = t_r;
    fine_x_nxt    = fine_x_r;
    first_nxt     = first_r;
    row_step_nxt  = row_step_r;
    acc_valid_nxt = 1'b0;
    acc_wr_nxt    = 1'b0;
    acc_addr_nxt  = '0;
    acc_data_nxt  = '0;
    case (in_kind)
      KIND_REG_WRITE: begin
        case (in_reg_index)
          PORT_CONTROL: begin
            t_nxt[11:10] = in_write_data[1:0];
            row_step_nxt = in_write_data[2];
          end
          PORT_SCROLL: begin
            if (first_r) begin
              t_nxt[4:0] = in_write_data[7:3];
              fine_x_nxt = in_write_data[2:0];
            end else begin
              t_nxt[9:5]   = in_write_data[7:3];
              t_nxt[14:12] = in_write_data[2:0];
            end
            first_nxt = ~first_r;
          end
          PORT_ADDRESS: begin
            if (first_r) begin
              t_nxt[13:8] = in_write_data[5:0];
              t_nxt[14]   = 1'b0;
            end else begin
              t_nxt[7:0] = in_write_data;
              v_nxt      = {t_r[14:8], in_write_data};
            end
            first_nxt = ~first_r;
          end
          PORT_DATA: begin
            acc_valid_nxt = 1'b1;
            acc_wr_nxt    = 1'b1;
            acc_addr_nxt  = v_r;
            acc_data_nxt  = in_write_data;
            v_nxt         = v_stepped;
          end
          default: ;
        endcase
      end
      KIND_REG_READ: begin
        case (in_reg_index)
          PORT_STATUS: first_nxt = 1'b1;
          PORT_DATA: begin
            acc_valid_nxt = 1'b1;
            acc_addr_nxt  = v_r;
            v_nxt         = v_stepped;
          end
          default: ;
        endcase
      end
      KIND_INC_X:  v_nxt = inc_x(v_r);
      KIND_INC_Y:  v_nxt = inc_y(v_r);
      KIND_COPY_H: begin
        v_nxt[4:0] = t_r[4:0];
        v_nxt[10]  = t_r[10];
      end
      KIND_COPY_V: begin
        v_nxt[9:5]   = t_r[9:5];
        v_nxt[14:11] = t_r[14:11];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      t_r         <= '0;
      fine_x_r    <= '0;
      first_r     <= 1'b1;
      row_step_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        v_r        <= v_nxt;
        t_r        <= t_nxt;
        fine_x_r   <= fine_x_nxt;
        first_r    <= first_nxt;
        row_step_r <= row_step_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_valid;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      acc_valid_r <= acc_valid_nxt;
      acc_wr_r    <= acc_wr_nxt;
      acc_addr_r  <= acc_addr_nxt;
      acc_data_r  <= acc_data_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_access_valid    = acc_valid_r;
  assign out_access_is_write = acc_wr_r;
  assign out_access_address  = acc_addr_r;
  assign out_access_data     = acc_data_r;
  assign out_current_address = v_r;
  assign out_fine_scroll_x   = fine_x_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_access_valid |->
      !out_access_is_write && out_access_address == '0 && out_access_data == '0)
    else $error("access fields not cleared without access");

  a_read_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_access_valid && !out_access_is_write |-> out_access_data == '0)
    else $error("read access carries data");

  a_copy_h: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_kind == KIND_COPY_H |=>
      out_current_address[4:0] == $past(t_r[4:0]) &&
      out_current_address[10] == $past(t_r[10]))
    else $error("horizontal copy mismatch");

  a_toggle_status: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_kind == KIND_REG_READ && in_reg_index == PORT_STATUS |=> first_r)
    else $error("status read did not reset write toggle");

endmodule

`default_nettype wire

>>> tb/scroll_address_register_unit_test.sv
`timescale 1ns / 100ps
// testbench for scroll_address_register_unit: directed table then weighted random requests
// checks every result against a table entry or a local scroll/address predictor; depends on sar_pkg and the rtl
module scroll_address_register_unit_test;
  import sar_pkg::*;

  localparam int RANDOM_REQUESTS = 925;
  localparam int CYCLE_LIMIT = 200000;
  localparam int STEADY_FROM = 300;
  localparam int STEADY_TO = 450;
  localparam int DRAIN_AT = 600;
  localparam int IDLE_PCT = 20;
  localparam logic [2:0] KIND_UNUSED = 3'd6;
  localparam logic [2:0] PORT_SPARE = 3'd3;
  localparam logic [4:0] ROW_WRAP_NT = 5'd29;
  localparam logic [4:0] ROW_WRAP = 5'd31;
  localparam addr_t ROW_PITCH = addr_t'(32);
  localparam addr_t COL_PITCH = addr_t'(1);
  localparam port_t LIVE_PORTS [5] = '{PORT_CONTROL, PORT_STATUS, PORT_SCROLL, PORT_ADDRESS,
                                       PORT_DATA};

  typedef struct packed {
    logic  acc_valid;
    logic  acc_write;
    addr_t acc_addr;
    byte_t acc_data;
    addr_t cur_addr;
    fine_t fine_x;
  } scroll_result_t;

  typedef struct packed {
    logic [2:0]     kind;
    logic [2:0]     port;
    byte_t          data;
    logic           rend;
    logic           known;
    scroll_result_t want;
  } stim_row_t;

  localparam int N_DIRECTED = 25;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{KIND_REG_READ,  PORT_DATA,    8'h00, 1'b0, 1'b1, '{1'b1, 1'b0, 15'h0000, 8'h00, 15'h0001, 3'd0}},
    '{KIND_REG_WRITE, PORT_CONTROL, 8'hFF, 1'b0, 1'b1, '{1'b0, 1'b0, 15'h0000, 8'h00, 15'h0001, 3'd0}},
    '{KIND_REG_WRITE, PORT_ADDRESS, 8'hFF, 1'b0, 1'b1, '{1'b0, 1'b0, 15'h0000, 8'h00, 15'h0001, 3'd0}},
    '{KIND_REG_WRITE, PORT_ADDRESS, 8'hFF, 1'b0, 1'b1, '{1'b0, 1'b0, 15'h0000, 8'h00, 15'h3FFF, 3'd0}},
    '{KIND_REG_WRITE, PORT_DATA,    8'hA5, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, PORT_SCROLL,  8'hFF, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, PORT_SCROLL,  8'hFF, 1'b0, 1'b0, '0},
    '{KIND_COPY_V,    PORT_CONTROL, 8'h00, 1'b0, 1'b0, '0},
    '{KIND_COPY_H,    PORT_CONTROL, 8'h00, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, PORT_DATA,    8'h00, 1'b0, 1'b1, '{1'b1, 1'b1, 15'h7FFF, 8'h00, 15'h001F, 3'd7}},
    '{KIND_REG_READ,  PORT_STATUS,  8'h00, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, PORT_SCROLL,  8'h00, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, PORT_SCROLL,  8'hEF, 1'b0, 1'b0, '0},
    '{KIND_COPY_V,    PORT_CONTROL, 8'h00, 1'b0, 1'b0, '0},
    '{KIND_INC_Y,     PORT_CONTROL, 8'h00, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, PORT_SCROLL,  8'hF8, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, PORT_SCROLL,  8'hFF, 1'b0, 1'b0, '0},
    '{KIND_COPY_V,    PORT_CONTROL, 8'h00, 1'b0, 1'b0, '0},
    '{KIND_INC_Y,     PORT_CONTROL, 8'h00, 1'b0, 1'b0, '0},
    '{KIND_INC_X,     PORT_CONTROL, 8'h00, 1'b0, 1'b0, '0},
    '{KIND_REG_WRITE, PORT_DATA,    8'h3C, 1'b1, 1'b0, '0},
    '{KIND_REG_WRITE, PORT_SPARE,   8'h5A, 1'b1, 1'b0, '0},
    '{KIND_REG_READ,  PORT_CONTROL, 8'hFF, 1'b0, 1'b0, '0},
    '{KIND_UNUSED,    PORT_DATA,    8'hFF, 1'b1, 1'b0, '0},
    '{KIND_REG_READ,  PORT_DATA,    8'h00, 1'b1, 1'b0, '0}
  };

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [2:0] in_kind = '0;
  logic [2:0] in_reg_index = '0;
  byte_t      in_write_data = '0;
  logic       in_rendering_active = 1'b0;
  logic       out_ready = 1'b0;
  logic       steady = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       out_access_valid;
  logic       out_access_is_write;
  addr_t      out_access_address;
  byte_t      out_access_data;
  addr_t      out_current_address;
  fine_t      out_fine_scroll_x;

  addr_t cur_addr = '0;
  addr_t tmp_addr = '0;
  fine_t fine_x = '0;
  logic  first_write = 1'b1;
  logic  row_step = 1'b0;

  scroll_result_t pending_results [$];
  int mismatches = 0;
  int cycle_count = 0;

  scroll_address_register_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_reg_index        (in_reg_index),
    .in_write_data       (in_write_data),
    .in_rendering_active (in_rendering_active),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_access_valid    (out_access_valid),
    .out_access_is_write (out_access_is_write),
    .out_access_address  (out_access_address),
    .out_access_data     (out_access_data),
    .out_current_address (out_current_address),
    .out_fine_scroll_x   (out_fine_scroll_x)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic addr_t next_column(input addr_t a);
    addr_t n;
    n = a;
    if (a[4:0] == ROW_WRAP) begin
      n[4:0] = '0;
      n[10] = ~a[10];
    end else begin
      n = a + COL_PITCH;
    end
    return n;
  endfunction

  function automatic addr_t next_row(input addr_t a);
    logic [2:0] fy;
    logic [4:0] cy;
    logic       nt_y;
    fy = a[14:12];
    cy = a[9:5];
    nt_y = a[11];
    if (fy != 3'd7) begin
      return {fy + 3'd1, a[11:0]};
    end
    if (cy == ROW_WRAP_NT) begin
      cy = '0;
      nt_y = ~nt_y;
    end else if (cy == ROW_WRAP) begin
      cy = '0;
    end else begin
      cy = cy + 5'd1;
    end
    return {3'd0, nt_y, a[10], cy, a[4:0]};
  endfunction

  function automatic scroll_result_t port_access(input logic wr, input byte_t d, input logic r);
    scroll_result_t res;
    res = '0;
    res.acc_valid = 1'b1;
    res.acc_write = wr;
    res.acc_addr = cur_addr;
    res.acc_data = wr ? d : '0;
    if (r) begin
      cur_addr = next_row(cur_addr);
    end else begin
      cur_addr = cur_addr + (row_step ? ROW_PITCH : COL_PITCH);
    end
    return res;
  endfunction

  function automatic scroll_result_t apply_request(input logic [2:0] k, input logic [2:0] p,
                                                   input byte_t d, input logic r);
    scroll_result_t res;
    res = '0;
    case (k)
      KIND_REG_WRITE: begin
        case (p)
          PORT_CONTROL: begin
            tmp_addr[11:10] = d[1:0];
            row_step = d[2];
          end
          PORT_SCROLL: begin
            if (first_write) begin
              tmp_addr[4:0] = d[7:3];
              fine_x = d[2:0];
            end else begin
              tmp_addr[9:5] = d[7:3];
              tmp_addr[14:12] = d[2:0];
            end
            first_write = ~first_write;
          end
          PORT_ADDRESS: begin
            if (first_write) begin
              tmp_addr[14:8] = {1'b0, d[5:0]};
            end else begin
              tmp_addr[7:0] = d;
              cur_addr = tmp_addr;
            end
            first_write = ~first_write;
          end
          PORT_DATA: res = port_access(1'b1, d, r);
          default: ;
        endcase
      end
      KIND_REG_READ: begin
        if (p == PORT_STATUS) begin
          first_write = 1'b1;
        end else if (p == PORT_DATA) begin
          res = port_access(1'b0, d, r);
        end
      end
      KIND_INC_X: cur_addr = next_column(cur_addr);
      KIND_INC_Y: cur_addr = next_row(cur_addr);
      KIND_COPY_H: {cur_addr[10], cur_addr[4:0]} = {tmp_addr[10], tmp_addr[4:0]};
      KIND_COPY_V: {cur_addr[14:11], cur_addr[9:5]} = {tmp_addr[14:11], tmp_addr[9:5]};
      default: ;
    endcase
    res.cur_addr = cur_addr;
    res.fine_x = fine_x;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s at cycle %0d: got %h expected %h", what, cycle_count, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    scroll_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no request outstanding", 1, 0);
    end else begin
      want = pending_results.pop_front();
      if (out_access_valid !== want.acc_valid)
        report_mismatch("access_valid", out_access_valid, want.acc_valid);
      if (out_access_is_write !== want.acc_write)
        report_mismatch("access_is_write", out_access_is_write, want.acc_write);
      if (out_access_address !== want.acc_addr)
        report_mismatch("access_address", out_access_address, want.acc_addr);
      if (out_access_data !== want.acc_data)
        report_mismatch("access_data", out_access_data, want.acc_data);
      if (out_current_address !== want.cur_addr)
        report_mismatch("current_address", out_current_address, want.cur_addr);
      if (out_fine_scroll_x !== want.fine_x)
        report_mismatch("fine_scroll_x", out_fine_scroll_x, want.fine_x);
    end
  endtask

  task automatic send_request(input logic [2:0] k, input logic [2:0] p, input byte_t d,
                              input logic r, input logic known, input scroll_result_t want);
    scroll_result_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_reg_index <= p;
    in_write_data <= d;
    in_rendering_active <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_request(k, p, d, r);
    pending_results.push_back(known ? want : predicted);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_valid && out_ready) check_result();
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int         pick;
    logic [2:0] k;
    logic [2:0] p;
    byte_t      d;
    logic       r;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < N_DIRECTED; n++) begin
      send_request(DIRECTED[n].kind, DIRECTED[n].port, DIRECTED[n].data, DIRECTED[n].rend,
                   DIRECTED[n].known, DIRECTED[n].want);
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == STEADY_FROM) steady <= 1'b1;
      if (i == STEADY_TO) steady <= 1'b0;
      // let every outstanding request drain before going on
      if (i == DRAIN_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        k = KIND_REG_WRITE;
      end else if (pick < 65) begin
        k = KIND_REG_READ;
      end else if (pick < 92) begin
        k = 3'($urandom_range(KIND_COPY_V, KIND_INC_X));
      end else begin
        k = 3'($urandom_range(7));
      end
      p = ($urandom_range(9) < 8) ? LIVE_PORTS[$urandom_range(4)] : 3'($urandom_range(7));
      d = byte_t'($urandom_range(255));
      r = 1'($urandom_range(1));
      send_request(k, p, d, r, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> scroll_address_register_unit.f
design/sar_pkg.sv
design/scroll_address_register_unit.sv
tb/scroll_address_register_unit_test.sv
